// File: sv/todc_pkg.sv
// todc_pkg: shared types, item kind codes and month length lookup
// for the time of day calendar counter; no dependencies
package todc_pkg;

    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_SET_DATE = 2'd1;
    localparam logic [1:0] KIND_SET_TIME = 2'd2;
    localparam logic [1:0] KIND_SET_WDAY = 2'd3;

    localparam logic [5:0] SEC_LAST   = 6'd59;
    localparam logic [5:0] MIN_LAST   = 6'd59;
    localparam logic [4:0] HOUR_LAST  = 5'd23;
    localparam logic [3:0] MONTH_LAST = 4'd12;
    localparam logic [2:0] WDAY_LAST  = 3'd6;

    localparam logic [6:0] HOURS_PER_DAY  = 7'd24;
    localparam logic [6:0] MINS_PER_HOUR  = 7'd60;
    localparam logic [6:0] MONTHS_PER_YR  = 7'd12;
    localparam logic [2:0] DAYS_PER_WEEK  = 3'd7;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [2:0] weekday;
    } t_clock;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] new_month;
        logic [6:0] new_day;
        logic [6:0] new_hour;
        logic [6:0] new_minute;
        logic [2:0] new_weekday;
    } t_item;

    typedef struct packed {
        logic time_updated;
        logic date_updated;
    } t_flags;

    // fixed month lengths, no leap years; codes outside 1..12 give 0
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        len = 5'd31;
            default:                   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// File: sv/todc_next.sv
// todc_next: next clock/calendar value and update flags for one item
// depends on todc_pkg
module todc_next (
    input  todc_pkg::t_clock i_cur,
    input  todc_pkg::t_item  i_item,
    output todc_pkg::t_clock o_nxt,
    output todc_pkg::t_flags o_flags
);
    import todc_pkg::*;

    logic       sec_wrap;
    logic       min_wrap;
    logic       hour_wrap;
    logic       month_end;
    logic [3:0] set_month;
    logic [4:0] set_len;

    assign sec_wrap  = (i_cur.second >= SEC_LAST);
    assign min_wrap  = (i_cur.minute >= MIN_LAST);
    assign hour_wrap = (i_cur.hour >= HOUR_LAST);
    // a day left past the month end by a date set also wraps here
    assign month_end = (i_cur.day >= month_len(i_cur.month));

    // month is loaded first, the day is checked against the resulting month
    assign set_month = (i_item.new_month >= 7'd1 && i_item.new_month <= MONTHS_PER_YR)
                     ? i_item.new_month[3:0] : i_cur.month;
    assign set_len   = month_len(set_month);

    always_comb begin
        o_nxt   = i_cur;
        o_flags = '0;
        case (i_item.kind)
            KIND_TICK: begin
                if (!sec_wrap) begin
                    o_nxt.second = i_cur.second + 6'd1;
                end else begin
                    o_nxt.second = '0;
                    o_flags.time_updated = 1'b1;
                    if (!min_wrap) begin
                        o_nxt.minute = i_cur.minute + 6'd1;
                    end else begin
                        o_nxt.minute = '0;
                        if (!hour_wrap) begin
                            o_nxt.hour = i_cur.hour + 5'd1;
                        end else begin
                            o_nxt.hour = '0;
                            o_flags.date_updated = 1'b1;
                            o_nxt.weekday = (i_cur.weekday >= WDAY_LAST)
                                          ? 3'd0 : i_cur.weekday + 3'd1;
                            if (month_end) begin
                                o_nxt.day   = 5'd1;
                                o_nxt.month = (i_cur.month >= MONTH_LAST)
                                            ? 4'd1 : i_cur.month + 4'd1;
                            end else begin
                                o_nxt.day = i_cur.day + 5'd1;
                            end
                        end
                    end
                end
            end
            KIND_SET_DATE: begin
                o_nxt.month = set_month;
                if (i_item.new_day >= 7'd1 && i_item.new_day <= {2'b00, set_len}) begin
                    o_nxt.day = i_item.new_day[4:0];
                end
                o_flags.date_updated = 1'b1;
            end
            KIND_SET_TIME: begin
                if (i_item.new_hour < HOURS_PER_DAY) begin
                    o_nxt.hour = i_item.new_hour[4:0];
                end
                if (i_item.new_minute < MINS_PER_HOUR) begin
                    o_nxt.minute = i_item.new_minute[5:0];
                end
                o_nxt.second = '0;
                o_flags.time_updated = 1'b1;
            end
            KIND_SET_WDAY: begin
                if (i_item.new_weekday < DAYS_PER_WEEK) begin
                    o_nxt.weekday = i_item.new_weekday;
                    o_flags.date_updated = 1'b1;
                end
            end
            default: begin
                o_nxt   = i_cur;
                o_flags = '0;
            end
        endcase
    end

endmodule

// File: sv/time_of_day_calendar_counter_core.sv
// time of day and calendar counter, top level
// depends on todc_pkg and todc_next
//
// input channel: i_in_valid / o_in_stall carry one item (tick, set date,
// set time or set weekday). output channel: o_out_valid / i_out_stall carry
// one result per item: the full time and date after that item plus the
// time_updated and date_updated flags.
// an accepted item lands in an input register; the counter update is then
// computed from it and the counter registers, which are also the result
// register, take the new value once the result register is empty or its
// result transfers out. throughput is one item per cycle while the receiver
// does not stall, set by the single update stage between the input
// register and the counter registers.
// the input register keeps taking items while a result waits, as long as
// the update stage can hand off; if the receiver stalls and both the result
// and the input register are full, o_in_stall rises until the result moves.
// reset (synchronous, active low) empties both stages and sets the clock
// to 00:00:00, day 1, month 1, weekday 0.
module time_of_day_calendar_counter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_kind,
    input  logic [6:0] i_new_month,
    input  logic [6:0] i_new_day,
    input  logic [6:0] i_new_hour,
    input  logic [6:0] i_new_minute,
    input  logic [2:0] i_new_weekday,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [5:0] o_second,
    output logic [5:0] o_minute,
    output logic [4:0] o_hour,
    output logic [4:0] o_day,
    output logic [3:0] o_month,
    output logic [2:0] o_weekday,
    output logic       o_time_updated,
    output logic       o_date_updated
);
    import todc_pkg::*;

    logic   r_in_valid;
    t_item  r_item;
    logic   r_out_valid;
    t_clock r_clock;
    t_flags r_flags;

    t_clock n_clock;
    t_flags n_flags;
    logic   out_load;
    logic   in_load;

    // counters change only when a result is written, so they are the result
    assign out_load   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !out_load;
    assign in_load    = i_in_valid && !o_in_stall;

    todc_next u_next (
        .i_cur   (r_clock),
        .i_item  (r_item),
        .o_nxt   (n_clock),
        .o_flags (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_item <= '{kind: i_kind, new_month: i_new_month, new_day: i_new_day,
                        new_hour: i_new_hour, new_minute: i_new_minute,
                        new_weekday: i_new_weekday};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_clock     <= '{second: 6'd0, minute: 6'd0, hour: 5'd0,
                             day: 5'd1, month: 4'd1, weekday: 3'd0};
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_clock     <= n_clock;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_flags <= n_flags;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_second       = r_clock.second;
    assign o_minute       = r_clock.minute;
    assign o_hour         = r_clock.hour;
    assign o_day          = r_clock.day;
    assign o_month        = r_clock.month;
    assign o_weekday      = r_clock.weekday;
    assign o_time_updated = r_flags.time_updated;
    assign o_date_updated = r_flags.date_updated;

endmodule

// File: sv/todc_checker.sv
// todc_checker: port level checks for the calendar counter core
// bound to time_of_day_calendar_counter_core; no package needed
module todc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [5:0] o_second,
    input logic [5:0] o_minute,
    input logic [4:0] o_hour,
    input logic [4:0] o_day,
    input logic [3:0] o_month,
    input logic [2:0] o_weekday,
    input logic       o_time_updated
);

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a waiting result holds its values
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_second)
            && $stable(o_minute) && $stable(o_hour) && $stable(o_day)
            && $stable(o_month) && $stable(o_weekday))
        else $error("stalled result changed");

    // every shown value stays in its calendar range; the day is only checked to be nonzero
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_second < 6'd60 && o_minute < 6'd60 && o_hour < 5'd24
            && o_day != 5'd0 && o_month != 4'd0 && o_month < 4'd13 && o_weekday < 3'd7)
        else $error("clock value out of range");

    // a time update is either a minute rollover or a set time, both clear seconds
    a_tflag_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_time_updated |-> o_second == 6'd0)
        else $error("time update with nonzero seconds");

    // input side only backs up when the result is full and stalled
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stall without output backpressure");

endmodule

bind time_of_day_calendar_counter_core todc_checker u_todc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_second       (o_second),
    .o_minute       (o_minute),
    .o_hour         (o_hour),
    .o_day          (o_day),
    .o_month        (o_month),
    .o_weekday      (o_weekday),
    .o_time_updated (o_time_updated)
);
